// ===== design/b64d_pkg.sv =====
// Package for the streaming base64 decoder.
// Holds symbol codes, status codes and the result bundle type shared by the
// decoder and the result serializer. No dependencies.
`default_nettype none

package b64d_pkg;

  localparam int unsigned LEN_W  = 16;  // width of byte counts and total_length
  localparam int unsigned SYM_W  = 7;   // six-bit symbol plus marker codes
  localparam int unsigned ACC_W  = 18;  // three pending symbols
  localparam int unsigned GRP_W  = 24;  // one full group of three bytes

  localparam logic [SYM_W-1:0] SYM_SKIP    = 7'd64;
  localparam logic [SYM_W-1:0] SYM_PAD     = 7'd65;
  localparam logic [SYM_W-1:0] SYM_INVALID = 7'd66;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Everything one accepted character produces: up to three bytes taken from
  // the top of value, then an optional status result.
  typedef struct packed {
    logic [GRP_W-1:0] value;
    logic [1:0]       nbytes;
    logic             has_status;
    status_e          status;
    logic [LEN_W-1:0] base;
  } bundle_t;

endpackage

`default_nettype wire

// ===== design/b64d_decode.sv =====
// Input register, message state and character decode for the base64 decoder.
// Builds at most one result bundle per character; uses b64d_pkg.
`default_nettype none

module b64d_decode (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [15:0]                 cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [7:0]                  in_char_i,
  input  wire logic                        is_last_i,
  input  wire logic                        bundle_free_i,
  output      logic                        bundle_valid_o,
  output      b64d_pkg::bundle_t           bundle_o
);

  logic                             in_valid_q;
  logic [7:0]                       char_q;
  logic                             last_q;
  logic [15:0]                      cap_q;
  logic [b64d_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic [1:0]                       cnt_q, cnt_d;
  logic [b64d_pkg::LEN_W-1:0]       bc_q, bc_d;
  logic                             pad_q, pad_d;
  b64d_pkg::status_e                err_q, err_d, st_final;
  logic [b64d_pkg::SYM_W-1:0]       sym;
  logic                             active;
  logic [1:0]                       nb;
  logic [b64d_pkg::GRP_W-1:0]       val;
  logic [b64d_pkg::LEN_W:0]         sum1, sum2, sum3, cap_ext;
  logic                             no_result;
  logic                             proceed;

  function automatic logic [b64d_pkg::SYM_W-1:0] classify(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end else if (c == 8'h0A) begin
      d = {1'b0, b64d_pkg::SYM_SKIP};
    end else if (c == 8'h3D) begin
      d = {1'b0, b64d_pkg::SYM_PAD};
    end else begin
      d = {1'b0, b64d_pkg::SYM_INVALID};
    end
    return d[b64d_pkg::SYM_W-1:0];
  endfunction

  assign cap_ext = {1'b0, cap_q};
  assign sum1    = {1'b0, bc_q} + (b64d_pkg::LEN_W+1)'(1);
  assign sum2    = {1'b0, bc_q} + (b64d_pkg::LEN_W+1)'(2);
  assign sum3    = {1'b0, bc_q} + (b64d_pkg::LEN_W+1)'(3);

  always_comb begin
    sym      = classify(char_q);
    active   = (err_q == b64d_pkg::ST_OK) && !pad_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    pad_d    = pad_q;
    err_d    = err_q;
    nb       = 2'd0;
    val      = '0;

    if (active) begin
      if (sym == b64d_pkg::SYM_INVALID) begin
        err_d = b64d_pkg::ST_INVALID;
      end else if (sym == b64d_pkg::SYM_PAD) begin
        pad_d = 1'b1;
      end else if (sym != b64d_pkg::SYM_SKIP) begin
        if (cnt_q == 2'd3) begin
          acc_d = '0;
          cnt_d = 2'd0;
          if (sum3 > cap_ext) begin
            err_d = b64d_pkg::ST_OVERFLOW;
          end else begin
            nb  = 2'd3;
            val = {acc_q, sym[5:0]};
          end
        end else begin
          acc_d = {acc_q[11:0], sym[5:0]};
          cnt_d = cnt_q + 2'd1;
        end
      end
    end

    // A group completing here leaves no pending symbols, so at most one
    // of the group emit and the flush ever fires for a character.
    if (last_q && err_d == b64d_pkg::ST_OK) begin
      if (cnt_d == 2'd3) begin
        if (sum2 > cap_ext) begin
          err_d = b64d_pkg::ST_OVERFLOW;
        end else begin
          nb  = 2'd2;
          val = {acc_d, 6'd0};
        end
      end else if (cnt_d == 2'd2) begin
        if (sum1 > cap_ext) begin
          err_d = b64d_pkg::ST_OVERFLOW;
        end else begin
          nb  = 2'd1;
          val = {acc_d[11:0], 12'd0};
        end
      end
    end

    st_final = err_d;
    bc_d     = bc_q + b64d_pkg::LEN_W'(nb);

    if (last_q) begin
      acc_d = '0;
      cnt_d = 2'd0;
      bc_d  = '0;
      pad_d = 1'b0;
      err_d = b64d_pkg::ST_OK;
    end
  end

  // Characters that produce nothing retire even while the serializer is busy.
  assign no_result      = (nb == 2'd0) && !last_q;
  assign proceed        = in_valid_q && (no_result || bundle_free_i);
  assign in_ready_o     = !in_valid_q || proceed;
  assign bundle_valid_o = proceed && !no_result;

  always_comb begin
    bundle_o.value      = val;
    bundle_o.nbytes     = nb;
    bundle_o.has_status = last_q;
    bundle_o.status     = st_final;
    bundle_o.base       = bc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cap_q      <= 16'hFFFF;
      acc_q      <= '0;
      cnt_q      <= 2'd0;
      bc_q       <= '0;
      pad_q      <= 1'b0;
      err_q      <= b64d_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proceed) begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        bc_q  <= bc_d;
        pad_q <= pad_d;
        err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= in_char_i;
      last_q <= is_last_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64d_serial.sv =====
// Result register and serializer for the base64 decoder.
// Holds one bundle and hands out its results one request at a time; uses b64d_pkg.
`default_nettype none

module b64d_serial (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          bundle_valid_i,
  input  wire b64d_pkg::bundle_t             bundle_i,
  output      logic                          bundle_free_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [7:0]                    out_byte_o,
  output      logic                          byte_valid_o,
  output      logic                          run_end_o,
  output      logic                          message_end_o,
  output      logic [1:0]                    status_o,
  output      logic [b64d_pkg::LEN_W-1:0]    total_length_o
);

  b64d_pkg::bundle_t  bund_q;
  logic               bvalid_q;
  logic [1:0]         idx_q;
  logic [2:0]         nres;
  logic               last_res;
  logic               take;
  logic               is_byte;

  assign nres     = {1'b0, bund_q.nbytes} + {2'b00, bund_q.has_status};
  assign last_res = ({1'b0, idx_q} + 3'd1) == nres;
  assign take     = bvalid_q && out_ready_i;
  assign is_byte  = idx_q < bund_q.nbytes;

  assign bundle_free_o = !bvalid_q || (take && last_res);
  assign out_valid_o   = bvalid_q;
  assign byte_valid_o  = is_byte;
  assign run_end_o     = last_res;
  assign message_end_o = !is_byte;
  assign status_o      = is_byte ? 2'(b64d_pkg::ST_OK) : 2'(bund_q.status);

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = bund_q.value[23:16];
      2'd1:    out_byte_o = bund_q.value[15:8];
      2'd2:    out_byte_o = bund_q.value[7:0];
      default: out_byte_o = 8'd0;
    endcase
    if (!is_byte) begin
      out_byte_o     = 8'd0;
      total_length_o = bund_q.base + b64d_pkg::LEN_W'(bund_q.nbytes);
    end else begin
      total_length_o = bund_q.base + b64d_pkg::LEN_W'(idx_q) + b64d_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      if (bundle_free_o) begin
        bvalid_q <= bundle_valid_i;
        idx_q    <= 2'd0;
      end else if (take) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bundle_free_o && bundle_valid_i) begin
      bund_q <= bundle_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/base64_stream_decoder_core.sv =====
// Channel     Direction  Handshake                  Payload
// input       in         in_valid_i / in_ready_o    in_char_i, is_last_i
// result      out        out_valid_o / out_ready_i  out_byte_o .. total_length_o
// config      in         cfg_we_i                   cfg_wdata_i (out_capacity)
//
// A character is decoded in the cycle after it is accepted; one request enters per cycle
// while in_ready_o is high. Each result needs its own output handshake, so a character giving
// n results holds the serializer until all n are taken; newline and pending symbols skip it.
// Reset clears all message state and sets the capacity to 65535.
// A stalled output fills the bundle register, then the input register, then drops in_ready_o.
//
// Top level of the streaming base64 decoder; instantiates b64d_decode and
// b64d_serial and uses b64d_pkg.
`default_nettype none

module base64_stream_decoder_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [15:0]                 cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [7:0]                  in_char_i,
  input  wire logic                        is_last_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [7:0]                  out_byte_o,
  output      logic                        byte_valid_o,
  output      logic                        run_end_o,
  output      logic                        message_end_o,
  output      logic [1:0]                  status_o,
  output      logic [b64d_pkg::LEN_W-1:0]  total_length_o
);

  logic               bundle_valid;
  logic               bundle_free;
  b64d_pkg::bundle_t  bundle;

  b64d_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_char_i      (in_char_i),
    .is_last_i      (is_last_i),
    .bundle_free_i  (bundle_free),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  b64d_serial u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (bundle_valid),
    .bundle_i       (bundle),
    .bundle_free_o  (bundle_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_end_o      (run_end_o),
    .message_end_o  (message_end_o),
    .status_o       (status_o),
    .total_length_o (total_length_o)
  );

`ifndef SYNTHESIS
  // The status result always closes the run of its character.
  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> run_end_o && !byte_valid_o)
    else $error("status result does not end its run");

  // Byte results carry status ok, and status codes stay in range.
  a_status_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o && status_o == b64d_pkg::ST_OK) ||
                    (!byte_valid_o && status_o != 2'd3))
    else $error("bad status on result");

  // Within a run the length grows by one per byte and holds for the status.
  a_length_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && byte_valid_o && !run_end_o |=>
      out_valid_o &&
      ((byte_valid_o && total_length_o == $past(total_length_o) + 16'd1) ||
       (message_end_o && total_length_o == $past(total_length_o))))
    else $error("total_length out of step within a run");
`endif

endmodule

`default_nettype wire

// ===== test/base64_stream_decoder_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_decoder_core: random and directed character
// streams with a scoreboard that predicts every byte and status result. Depends on b64d_pkg.

typedef struct packed {
  logic [7:0]        data;
  logic              data_valid;
  logic              run_end;
  logic              msg_end;
  b64d_pkg::status_e status;
  logic [15:0]       total_len;
} decode_result_t;

class decoder_scoreboard;
  decode_result_t    expected_q[$];
  decode_result_t    step_q[$];
  logic [15:0]       capacity;
  logic [17:0]       acc;
  logic [1:0]        sym_cnt;
  logic [15:0]       byte_cnt;
  bit                pad_seen;
  b64d_pkg::status_e err;
  int unsigned       errors;

  function new();
    capacity = 16'hFFFF;
    errors   = 0;
    clear_message();
  endfunction

  function void clear_message();
    acc      = '0;
    sym_cnt  = '0;
    byte_cnt = '0;
    pad_seen = 1'b0;
    err      = b64d_pkg::ST_OK;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function logic [6:0] symbol_of(logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    if (c == 8'd10) return b64d_pkg::SYM_SKIP;
    if (c == "=") return b64d_pkg::SYM_PAD;
    return b64d_pkg::SYM_INVALID;
  endfunction

  // Emits n bytes from the top of a 24-bit group, unless that would overrun the capacity.
  function void emit_bytes(logic [23:0] value, int n);
    decode_result_t r;
    if (32'(byte_cnt) + n > 32'(capacity)) begin
      err = b64d_pkg::ST_OVERFLOW;
      return;
    end
    for (int i = 0; i < n; i++) begin
      byte_cnt     = byte_cnt + 16'd1;
      r            = '0;
      r.data       = value[23 - 8 * i -: 8];
      r.data_valid = 1'b1;
      r.status     = b64d_pkg::ST_OK;
      r.total_len  = byte_cnt;
      step_q.push_back(r);
    end
  endfunction

  function void note_request(logic [7:0] c, logic last);
    logic [6:0]     sym;
    decode_result_t r;
    step_q.delete();
    if (err == b64d_pkg::ST_OK && !pad_seen) begin
      sym = symbol_of(c);
      if (sym == b64d_pkg::SYM_INVALID) begin
        err = b64d_pkg::ST_INVALID;
      end else if (sym == b64d_pkg::SYM_PAD) begin
        pad_seen = 1'b1;
      end else if (sym != b64d_pkg::SYM_SKIP) begin
        if (sym_cnt == 2'd3) begin
          emit_bytes({acc, sym[5:0]}, 3);
          acc     = '0;
          sym_cnt = '0;
        end else begin
          acc     = {acc[11:0], sym[5:0]};
          sym_cnt = sym_cnt + 2'd1;
        end
      end
    end
    if (last) begin
      if (err == b64d_pkg::ST_OK) begin
        if (sym_cnt == 2'd3) emit_bytes({acc, 6'd0}, 2);
        else if (sym_cnt == 2'd2) emit_bytes({acc[11:0], 12'd0}, 1);
      end
      r           = '0;
      r.msg_end   = 1'b1;
      r.status    = err;
      r.total_len = byte_cnt;
      step_q.push_back(r);
      clear_message();
    end
    if (step_q.size() != 0) step_q[step_q.size() - 1].run_end = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_result(logic [7:0] data, logic dv, logic re, logic me, logic [1:0] st,
                    logic [15:0] tl);
    decode_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result with nothing expected: byte %02h status %0d", data, st));
      return;
    end
    e = expected_q.pop_front();
    if (data !== e.data) report($sformatf("out_byte %02h, expected %02h", data, e.data));
    if (dv !== e.data_valid)
      report($sformatf("byte_valid %b, expected %b", dv, e.data_valid));
    if (re !== e.run_end) report($sformatf("run_end %b, expected %b", re, e.run_end));
    if (me !== e.msg_end) report($sformatf("message_end %b, expected %b", me, e.msg_end));
    if (st !== e.status) report($sformatf("status %0d, expected %0d", st, e.status));
    if (tl !== e.total_len)
      report($sformatf("total_length %0d, expected %0d", tl, e.total_len));
  endtask
endclass

module base64_stream_decoder_core_test;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE      = 8;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_char_i   = '0;
  logic        is_last_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        run_end_o;
  logic        message_end_o;
  logic [1:0]  status_o;
  logic [b64d_pkg::LEN_W-1:0] total_length_o;

  decoder_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  bit          quiet       = 1'b0;
  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;

  base64_stream_decoder_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_char_i      (in_char_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_end_o      (run_end_o),
    .message_end_o  (message_end_o),
    .status_o       (status_o),
    .total_length_o (total_length_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: checks each accepted result and throttles out_ready_i.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(out_byte_o, byte_valid_o, run_end_o, message_end_o, status_o,
                        total_length_o);
      if ($urandom_range(0, 99) == 0) rx_idle = !rx_idle;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && rx_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    if (!quiet && tx_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(c, last);
    sent_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Waits until every expected result is out and the pipeline has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.capacity = value;
  endtask

  function automatic logic [7:0] alphabet_char(int unsigned idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? 8'("+") : 8'("/");
  endfunction

  // Mostly valid encoded text with stray newlines; the rest is noise and broken padding.
  task automatic send_message();
    logic [7:0]  text[$];
    int unsigned nsym;
    tx_idle = ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 3) != 0) begin
      nsym = $urandom_range(0, 12);
      for (int i = 0; i < nsym; i++) begin
        if ($urandom_range(0, 7) == 0) text.push_back(8'd10);
        text.push_back(alphabet_char($urandom_range(0, 63)));
      end
      if (nsym % 4 == 2 && $urandom_range(0, 1) == 1) begin
        text.push_back("=");
        text.push_back("=");
      end else if (nsym % 4 == 3 && $urandom_range(0, 1) == 1) begin
        text.push_back("=");
      end
      if (text.size() == 0) text.push_back(8'd10);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0: text.push_back(8'($urandom_range(0, 255)));
          1: text.push_back("=");
          2: text.push_back(8'd10);
          default: text.push_back(alphabet_char($urandom_range(0, 63)));
        endcase
      end
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  initial begin
    logic [15:0] caps[6];
    caps = '{16'd3, 16'hFFFF, 16'd6, 16'd1, 16'd0, 16'd2};
    caps[4] = 16'($urandom_range(0, 15));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_capacity(16'hFFFF);
    send_text("+/9z");
    send_text("QQ==");
    send_text("AB\nC");
    send_text("A");
    send_text("*A");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    send_text("\n");
    write_capacity(16'd0);
    send_text("zzzz");

    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      quiet = (p == 5);
      // A long hold-off on the result side lets the block back up into its input.
      if (p == 1) hold_left = 150;
      while (sent_count < 22 + 23 * (p + 1)) send_message();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
